// ===== rtl/erg_pkg.sv =====
// ----------------------------------------------------------------------------
// erg_pkg
// Shared types and constants for the eased ramp generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erg_pkg;

	// Q0.16 fraction, plus one extra bit so 1.0 can be held
	localparam int FRAC_BITS  = 16;
	localparam int CURVE_BITS = FRAC_BITS + 1;

	localparam logic [CURVE_BITS-1:0] ONE_Q16  = 17'h1_0000;
	localparam logic [FRAC_BITS-1:0]  MAX_Q16  = 16'hFFFF;
	localparam logic [FRAC_BITS-1:0]  HALF_Q16 = 16'h8000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_MOVE = 2'd1,
		OP_SNAP = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		EASE_LINEAR       = 2'd0,
		EASE_CUBIC_IN     = 2'd1,
		EASE_CUBIC_OUT    = 2'd2,
		EASE_CUBIC_IN_OUT = 2'd3
	} ease_t;

	// register file: word index taken from paddr[CFG_ADDR_BITS-1:2]
	localparam int         CFG_ADDR_BITS      = 3;
	localparam logic [0:0] REG_MOTION_ENABLED = 1'b0;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

// ===== rtl/erg_serial_mul.sv =====
// ----------------------------------------------------------------------------
// erg_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erg_serial_mul #(
	parameter int A_BITS = 17
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [A_BITS-1:0]                        a,
	input  logic [erg_pkg::CURVE_BITS-1:0]           b,
	output erg_pkg::unit_status_t                    status,
	output logic [A_BITS+erg_pkg::CURVE_BITS-1:0]    product
);
	import erg_pkg::*;

	localparam int P_BITS   = A_BITS + CURVE_BITS;
	localparam int CNT_BITS = $clog2(CURVE_BITS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(CURVE_BITS - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [A_BITS-1:0]   a_q;
	logic [P_BITS-1:0]   p_q;
	logic [A_BITS:0]     sum;

	// upper half accumulates, lower half holds the unused multiplier bits
	assign sum = {1'b0, p_q[P_BITS-1:CURVE_BITS]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= P_BITS'(b);
		end else if (busy_q) begin
			p_q <= {sum, p_q[CURVE_BITS-1:1]};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign product     = p_q;

endmodule

// ===== rtl/erg_serial_div.sv =====
// ----------------------------------------------------------------------------
// erg_serial_div
// Restoring divider giving the Q0.16 fraction num/den, one quotient bit per
// cycle. Expects num < den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erg_serial_div #(
	parameter int T_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [T_BITS-1:0]              num,
	input  logic [T_BITS-1:0]              den,
	output erg_pkg::unit_status_t          status,
	output logic [erg_pkg::FRAC_BITS-1:0]  quot
);
	import erg_pkg::*;

	localparam int CNT_BITS = $clog2(FRAC_BITS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(FRAC_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [T_BITS-1:0]    rem_q;
	logic [T_BITS-1:0]    den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [T_BITS:0]      rem2;
	logic [T_BITS:0]      diff;
	logic                 ge;

	// remainder stays below den, so the doubled value fits in T_BITS+1
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[T_BITS-1:0] : rem2[T_BITS-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quot        = quot_q;

endmodule

// ===== rtl/eased_ramp_generator_top.sv =====
// ----------------------------------------------------------------------------
// eased_ramp_generator_top
// Moves a signed Q1.15 value toward a target over a duration in milliseconds
// along a linear or cubic ease-in, ease-out or ease-in-out curve. Every
// transaction (tick, move or snap) returns exactly one result. Snaps, moves,
// idle ticks and ticks that end a ramp go from decode straight to the output
// state. A tick in the middle of a ramp runs a bit-serial divide for the
// progress fraction and then one (linear) or three (cubic curves) passes of a
// shared bit-serial multiplier; no new transaction is taken until the result
// is loaded. A finished result sits in an output register while the next
// transaction is taken. motion_enabled is written through the APB port at
// byte address 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eased_ramp_generator_top #(
	parameter int VALUE_BITS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic signed [15:0]                 target_value,
	input  logic [15:0]                        duration_ms,
	input  logic [1:0]                         ease_select,
	input  logic [15:0]                        delta_ms,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 current_value,
	output logic                               changed,
	output logic                               moving,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [erg_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import erg_pkg::*;

	localparam int SPAN_BITS   = VALUE_BITS + 1;
	localparam int MUL_A_BITS  = (SPAN_BITS > CURVE_BITS) ? SPAN_BITS : CURVE_BITS;
	localparam int MUL_P_BITS  = MUL_A_BITS + CURVE_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_SQUARE = 3'd3;
	localparam logic [2:0] ST_CUBE   = 3'd4;
	localparam logic [2:0] ST_SCALE  = 3'd5;
	localparam logic [2:0] ST_PUT    = 3'd6;

	logic [2:0]                    state_q;
	logic                          motion_enabled_q;

	// ramp state
	logic signed [VALUE_BITS-1:0]  start_q;
	logic signed [VALUE_BITS-1:0]  present_q;
	logic signed [VALUE_BITS-1:0]  goal_q;
	logic [TIME_BITS-1:0]          elapsed_q;
	logic [TIME_BITS-1:0]          total_q;
	logic [1:0]                    ease_q;

	// latched transaction
	logic [1:0]                    op_q;
	logic signed [VALUE_BITS-1:0]  target_q;
	logic [TIME_BITS-1:0]          dur_q;
	logic [1:0]                    ease_in_q;
	logic [TIME_BITS-1:0]          delta_q;

	// tick working registers
	logic [FRAC_BITS-1:0]          t_q;
	logic [CURVE_BITS-1:0]         x_q;
	logic [SPAN_BITS-1:0]          mag_q;
	logic                          span_neg_q;
	logic                          changed_q;

	// output register
	logic                          out_valid_q;
	logic signed [15:0]            current_value_q;
	logic                          changed_out_q;
	logic                          moving_q;

	logic                          moving_now;
	logic [TIME_BITS:0]            elapsed_sum;
	logic [TIME_BITS-1:0]          elapsed_next;
	logic signed [SPAN_BITS-1:0]   span;
	logic [SPAN_BITS-1:0]          span_mag;
	logic [CURVE_BITS-1:0]         x_from_t;
	logic [CURVE_BITS-1:0]         prod_q16;
	logic [CURVE_BITS-1:0]         ease_out_v;
	logic [CURVE_BITS-1:0]         in_out_hi_v;
	logic [CURVE_BITS+1:0]         in_out_lo_v;
	logic [FRAC_BITS-1:0]          curve;
	logic [SPAN_BITS-1:0]          step;
	logic [SPAN_BITS-1:0]          step_signed;
	logic [SPAN_BITS-1:0]          new_sum;
	logic signed [VALUE_BITS-1:0]  new_value;
	logic                          out_load;
	logic                          cfg_write;
	logic [0:0]                    reg_idx;

	logic                          div_start;
	unit_status_t                  div_status;
	logic [FRAC_BITS-1:0]          div_quot;

	logic                          mul_start;
	logic [MUL_A_BITS-1:0]         mul_a;
	logic [CURVE_BITS-1:0]         mul_b;
	unit_status_t                  mul_status;
	logic [MUL_P_BITS-1:0]         mul_product;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign reg_idx   = paddr[CFG_ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MOTION_ENABLED) begin
			prdata[0] = motion_enabled_q;
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	assign moving_now   = (elapsed_q < total_q);
	assign elapsed_sum  = {1'b0, elapsed_q} + {1'b0, delta_q};
	assign elapsed_next = (elapsed_sum < {1'b0, total_q}) ? elapsed_sum[TIME_BITS-1:0] : total_q;

	assign span     = SPAN_BITS'(goal_q) - SPAN_BITS'(start_q);
	assign span_mag = span[SPAN_BITS-1] ? (~span + 1'b1) : span;

	// curve input from the progress fraction
	always_comb begin
		case (ease_q)
			EASE_CUBIC_OUT:    x_from_t = ONE_Q16 - {1'b0, div_quot};
			EASE_CUBIC_IN_OUT: begin
				if (div_quot < HALF_Q16) begin
					x_from_t = {1'b0, div_quot};
				end else begin
					x_from_t = (ONE_Q16 - {1'b0, div_quot}) << 1;
				end
			end
			default:           x_from_t = {1'b0, div_quot};
		endcase
	end

	// product >> 16: x^2 in the square pass, x^3 in the cube pass
	assign prod_q16    = mul_product[FRAC_BITS +: CURVE_BITS];
	assign ease_out_v  = ONE_Q16 - prod_q16;
	assign in_out_hi_v = ONE_Q16 - (prod_q16 >> 1);
	assign in_out_lo_v = {prod_q16, 2'b00};

	always_comb begin
		case (ease_q)
			EASE_CUBIC_IN:  curve = prod_q16[FRAC_BITS-1:0];
			EASE_CUBIC_OUT: curve = ease_out_v[FRAC_BITS] ? MAX_Q16 : ease_out_v[FRAC_BITS-1:0];
			EASE_CUBIC_IN_OUT: begin
				if (t_q < HALF_Q16) begin
					curve = (|in_out_lo_v[CURVE_BITS+1:FRAC_BITS]) ? MAX_Q16
						: in_out_lo_v[FRAC_BITS-1:0];
				end else begin
					curve = in_out_hi_v[FRAC_BITS] ? MAX_Q16 : in_out_hi_v[FRAC_BITS-1:0];
				end
			end
			default:        curve = t_q;
		endcase
	end

	// step is truncated toward zero: scale the magnitude, then restore the sign
	assign step        = mul_product[FRAC_BITS +: SPAN_BITS];
	assign step_signed = span_neg_q ? (~step + 1'b1) : step;
	assign new_sum     = SPAN_BITS'(start_q) + step_signed;
	assign new_value   = new_sum[VALUE_BITS-1:0];

	// ------------------------------------------------------------------
	// serial units
	// ------------------------------------------------------------------
	assign div_start = (state_q == ST_DECODE) && (op_q == OP_TICK) && moving_now
		&& (elapsed_next != total_q);

	erg_serial_div #(
		.T_BITS (TIME_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed_next),
		.den    (total_q),
		.status (div_status),
		.quot   (div_quot)
	);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_DIV: begin
				if (div_status.done) begin
					mul_start = 1'b1;
					if (ease_q == EASE_LINEAR) begin
						mul_a = MUL_A_BITS'(mag_q);
						mul_b = {1'b0, div_quot};
					end else begin
						mul_a = MUL_A_BITS'(x_from_t);
						mul_b = x_from_t;
					end
				end
			end
			ST_SQUARE: begin
				if (mul_status.done) begin
					mul_start = 1'b1;
					mul_a     = MUL_A_BITS'(prod_q16);
					mul_b     = x_q;
				end
			end
			ST_CUBE: begin
				if (mul_status.done) begin
					mul_start = 1'b1;
					mul_a     = MUL_A_BITS'(mag_q);
					mul_b     = {1'b0, curve};
				end
			end
			default: begin
			end
		endcase
	end

	erg_serial_mul #(
		.A_BITS (MUL_A_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.status  (mul_status),
		.product (mul_product)
	);

	// ------------------------------------------------------------------
	// sequencer and ramp state
	// ------------------------------------------------------------------
	assign out_load = (state_q == ST_PUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			motion_enabled_q <= 1'b1;
			out_valid_q      <= 1'b0;
			start_q          <= '0;
			present_q        <= '0;
			goal_q           <= '0;
			elapsed_q        <= '0;
			total_q          <= '0;
			ease_q           <= EASE_LINEAR;
		end else begin
			if (cfg_write && (reg_idx == REG_MOTION_ENABLED)) begin
				motion_enabled_q <= pwdata[0];
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_PUT;
					case (op_q)
						OP_TICK: begin
							if (moving_now) begin
								elapsed_q <= elapsed_next;
								if (elapsed_next == total_q) begin
									present_q <= goal_q;
								end else begin
									state_q <= ST_DIV;
								end
							end
						end
						OP_MOVE: begin
							if (target_q == goal_q && moving_now) begin
								// already heading there
							end else if (target_q == present_q && !moving_now) begin
								// already at rest there
							end else if (!motion_enabled_q || dur_q == '0) begin
								start_q   <= target_q;
								present_q <= target_q;
								goal_q    <= target_q;
								elapsed_q <= '0;
								total_q   <= '0;
							end else begin
								start_q   <= present_q;
								goal_q    <= target_q;
								total_q   <= dur_q;
								elapsed_q <= '0;
								ease_q    <= ease_in_q;
							end
						end
						OP_SNAP: begin
							start_q   <= target_q;
							present_q <= target_q;
							goal_q    <= target_q;
							elapsed_q <= '0;
							total_q   <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= (ease_q == EASE_LINEAR) ? ST_SCALE : ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (mul_status.done) begin
						state_q <= ST_CUBE;
					end
				end
				ST_CUBE: begin
					if (mul_status.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (mul_status.done) begin
						present_q <= new_value;
						state_q   <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q      <= opcode;
			target_q  <= VALUE_BITS'(target_value);
			dur_q     <= TIME_BITS'(duration_ms);
			ease_in_q <= ease_select;
			delta_q   <= TIME_BITS'(delta_ms);
		end
		if (state_q == ST_DECODE) begin
			mag_q      <= span_mag;
			span_neg_q <= span[SPAN_BITS-1];
			changed_q  <= (op_q == OP_TICK) && moving_now && (elapsed_next == total_q)
				&& (goal_q != present_q);
		end
		if (state_q == ST_DIV && div_status.done) begin
			t_q <= div_quot;
			x_q <= x_from_t;
		end
		if (state_q == ST_SCALE && mul_status.done) begin
			changed_q <= (new_value != present_q);
		end
		if (out_load) begin
			current_value_q <= 16'(present_q);
			changed_out_q   <= changed_q;
			moving_q        <= moving_now;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign current_value = current_value_q;
	assign changed       = changed_out_q;
	assign moving        = moving_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
`ifndef ASSERT_OFF
	a_elapsed_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q <= total_q)
		else $error("elapsed time ran past the ramp duration");

	a_rest_on_goal: assert property (@(posedge clk) disable iff (!arst_n)
		(elapsed_q == total_q) |-> (present_q == goal_q))
		else $error("value at rest is not on the goal");

	a_mul_done_in_curve: assert property (@(posedge clk) disable iff (!arst_n)
		mul_status.done |->
			(state_q == ST_SQUARE || state_q == ST_CUBE || state_q == ST_SCALE))
		else $error("multiplier finished outside a multiply step");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_status.busy && div_status.busy))
		else $error("divider and multiplier busy together");
`endif

endmodule
